/* hdl/sorted_insert_priority_queue_assert.svh */
// Assertion macros shared by the priority queue RTL.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define SIPQ_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define SIPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sipq_pkg.sv */
// Package for the sorted insert priority queue: sizes, codes and word types.
// Used by sipq_cell and sorted_insert_priority_queue; depends on nothing.
`timescale 1ns / 1ps

package sipq_pkg;

    localparam int DEPTH      = 16;
    localparam int PRIO_WIDTH = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic       FUNC_INSERT   = 1'b0;
    localparam logic       FUNC_REMOVE   = 1'b1;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] item_priority;
        logic [7:0]  item_payload;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] head_priority;
        logic [7:0]  head_payload;
        logic [4:0]  entry_count;
        logic        queue_empty;
        logic        queue_full;
    } t_out_word;

    typedef struct packed {
        logic [PRIO_WIDTH-1:0] prio;
        logic [7:0]            payload;
    } t_entry;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry entry;
    } t_cell_ctrl;

endpackage

/* hdl/sorted_insert_priority_queue.sv */
// Sorted insert priority queue: one instruction word in, one result word out
// in the next cycle. Every word is taken in the cycle it is offered; busy stays low.
// The result strobe o_done lasts a single cycle and cannot be held off, so the
// receiver must capture it then. Entries sit in a chain of cells ordered by
// priority with the head in the first cell; an insert or remove updates all cells
// at once, so the result register is the only delay between a word and its
// result. Depends on sipq_pkg, sipq_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_insert_priority_queue_assert.svh"

module sorted_insert_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sipq_pkg::t_in_word  i_in,
    output logic                o_done,
    output sipq_pkg::t_out_word o_result
);

    logic                       accept;
    logic                       is_full;
    logic                       is_empty;
    logic                       do_insert;
    logic                       do_remove;
    logic [sipq_pkg::CNT_W-1:0] r_count;
    logic [sipq_pkg::CNT_W-1:0] n_count;
    logic                       r_done;
    sipq_pkg::t_out_word        r_result;
    sipq_pkg::t_out_word        n_result;
    sipq_pkg::t_cell_ctrl       ctrl;
    logic [sipq_pkg::DEPTH-1:0] occupied;
    logic [sipq_pkg::DEPTH-1:0] keep;
    sipq_pkg::t_entry           entries [sipq_pkg::DEPTH];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (r_count == sipq_pkg::CNT_W'(sipq_pkg::DEPTH));
    assign is_empty = (r_count == '0);
    assign do_insert = accept && (i_in.func == sipq_pkg::FUNC_INSERT) && !is_full;
    assign do_remove = accept && (i_in.func == sipq_pkg::FUNC_REMOVE) && !is_empty;

    assign ctrl.insert        = do_insert;
    assign ctrl.remove        = do_remove;
    assign ctrl.entry.prio    = sipq_pkg::PRIO_WIDTH'(i_in.item_priority);
    assign ctrl.entry.payload = i_in.item_payload;

    // The first r_count cells hold live entries.
    always_comb begin
        for (int i = 0; i < sipq_pkg::DEPTH; i++) begin
            occupied[i] = (sipq_pkg::CNT_W'(i) < r_count);
        end
    end

    for (genvar g = 0; g < sipq_pkg::DEPTH; g++) begin : g_cell
        logic             left_keep;
        sipq_pkg::t_entry left_entry;
        sipq_pkg::t_entry right_entry;

        // The head cell behaves as if a kept entry stood before it.
        if (g == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = ctrl.entry;
        end else begin : g_mid
            assign left_keep  = keep[g-1];
            assign left_entry = entries[g-1];
        end

        if (g == sipq_pkg::DEPTH - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = entries[g+1];
        end

        sipq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occupied   (occupied[g]),
            .i_left_keep  (left_keep),
            .i_left_entry (left_entry),
            .i_right_entry(right_entry),
            .o_keep       (keep[g]),
            .o_entry      (entries[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + 1'b1;
        end else if (do_remove) begin
            n_count = r_count - 1'b1;
        end

        n_result = '0;
        if (accept && (i_in.func == sipq_pkg::FUNC_INSERT) && is_full) begin
            n_result.status = sipq_pkg::STATUS_FULL;
        end else if (accept && (i_in.func == sipq_pkg::FUNC_REMOVE) && is_empty) begin
            n_result.status = sipq_pkg::STATUS_EMPTY;
        end else begin
            n_result.status = sipq_pkg::STATUS_DONE;
        end
        if (do_remove) begin
            n_result.head_priority = 16'(entries[0].prio);
            n_result.head_payload  = entries[0].payload;
        end
        n_result.entry_count = 5'(n_count);
        n_result.queue_empty = (n_count == '0);
        n_result.queue_full  = (n_count == sipq_pkg::CNT_W'(sipq_pkg::DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `SIPQ_ASSERT_NOW(a_count_bound, r_count <= sipq_pkg::CNT_W'(sipq_pkg::DEPTH), "count exceeds depth")
    `SIPQ_ASSERT_NEXT(a_one_result, accept, o_done, "accepted word produced no result")
    `SIPQ_ASSERT_NEXT(a_no_spurious, !accept, !o_done, "result without an accepted word")
    `SIPQ_ASSERT_NEXT(a_full_refused, accept && (i_in.func == sipq_pkg::FUNC_INSERT) && is_full, (r_count == $past(r_count)) && (o_result.status == sipq_pkg::STATUS_FULL), "insert into full queue changed state")
    `SIPQ_ASSERT_NOW(a_head_order, (r_count < sipq_pkg::CNT_W'(2)) || (entries[0].prio <= entries[1].prio), "head cells out of order")

endmodule

/* hdl/sipq_cell.sv */
// One slot of the sorted chain: holds an entry and exchanges it with its neighbours.
// Depends on sipq_pkg for the entry and control types.
`timescale 1ns / 1ps

module sipq_cell (
    input  logic                i_clk,
    input  sipq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  logic                i_left_keep,
    input  sipq_pkg::t_entry    i_left_entry,
    input  sipq_pkg::t_entry    i_right_entry,
    output logic                o_keep,
    output sipq_pkg::t_entry    o_entry
);

    sipq_pkg::t_entry r_entry;
    sipq_pkg::t_entry n_entry;

    // A held entry of smaller or equal priority stays put, so ties remain in arrival order.
    assign o_keep  = i_occupied && (r_entry.prio <= i_ctrl.entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_ctrl.entry : i_left_entry;
            end
        end else if (i_ctrl.remove) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for sorted_insert_priority_queue: directed and random words
// are checked against a stable insertion-sort model of the queue.
// Depends on sipq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTED   = 10;

    typedef enum {PRIO_TIES, PRIO_FULL, PRIO_EDGES} t_prio_mode;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    sipq_pkg::t_in_word  i_in    = '0;
    logic                o_done;
    sipq_pkg::t_out_word o_result;

    // Model of the queue contents, head first, and the results still owed by the block.
    sipq_pkg::t_entry    held_entries[$];
    sipq_pkg::t_out_word pending_results[$];

    int mismatches     = 0;
    int results_seen   = 0;
    int inserts_done   = 0;
    int removes_done   = 0;
    int refused_full   = 0;
    int refused_empty  = 0;

    sorted_insert_priority_queue u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic sipq_pkg::t_in_word make_word(input logic func,
                                                     input logic [15:0] prio,
                                                     input logic [7:0] payload);
        sipq_pkg::t_in_word w;
        w.func          = func;
        w.item_priority = prio;
        w.item_payload  = payload;
        return w;
    endfunction

    // Applies one word to the model and returns the result the block should give.
    function automatic sipq_pkg::t_out_word apply_queue_op(input sipq_pkg::t_in_word w);
        sipq_pkg::t_out_word res;
        sipq_pkg::t_entry    e;
        int                  pos;
        res = '0;
        res.status = sipq_pkg::STATUS_DONE;
        if (w.func == sipq_pkg::FUNC_INSERT) begin
            if (held_entries.size() >= sipq_pkg::DEPTH) begin
                res.status = sipq_pkg::STATUS_FULL;
                refused_full++;
            end else begin
                e.prio    = w.item_priority[sipq_pkg::PRIO_WIDTH-1:0];
                e.payload = w.item_payload;
                // The new entry goes behind every entry of equal priority.
                pos = held_entries.size();
                while (pos > 0 && held_entries[pos-1].prio > e.prio)
                    pos--;
                held_entries.insert(pos, e);
                inserts_done++;
            end
        end else begin
            if (held_entries.size() == 0) begin
                res.status = sipq_pkg::STATUS_EMPTY;
                refused_empty++;
            end else begin
                e = held_entries.pop_front();
                res.head_priority[sipq_pkg::PRIO_WIDTH-1:0] = e.prio;
                res.head_payload = e.payload;
                removes_done++;
            end
        end
        res.entry_count = 5'(held_entries.size());
        res.queue_empty = (held_entries.size() == 0);
        res.queue_full  = (held_entries.size() == sipq_pkg::DEPTH);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Results are checked before the word accepted at the same edge is predicted.
    always @(posedge i_clk) begin : result_monitor
        sipq_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_done) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("unexpected result word %h", o_result);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, o_result.status);
                    check_field("head_priority", want.head_priority, o_result.head_priority);
                    check_field("head_payload", want.head_payload, o_result.head_payload);
                    check_field("entry_count", want.entry_count, o_result.entry_count);
                    check_field("queue_empty", want.queue_empty, o_result.queue_empty);
                    check_field("queue_full", want.queue_full, o_result.queue_full);
                end
            end
            if (start && !busy)
                pending_results.push_back(apply_queue_op(i_in));
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Each cycle before the word is offered is idle with the given chance in a hundred.
    task automatic send_word(input sipq_pkg::t_in_word w, input int idle_pct);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= w;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic test_remove_from_empty();
        send_word(make_word(sipq_pkg::FUNC_REMOVE, 16'hFFFF, 8'hFF), 0);
    endtask

    // Arrival order is scrambled and includes ties and both priority extremes.
    task automatic test_fill_and_overflow();
        logic [15:0] fill_prio[16];
        fill_prio = '{16'hFFFF, 16'h0000, 16'h0005, 16'h0005, 16'h0005, 16'h8000,
                      16'h0001, 16'h7FFF, 16'h0003, 16'h0002, 16'h0005, 16'hFFFE,
                      16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00};
        for (int k = 0; k < sipq_pkg::DEPTH; k++)
            send_word(make_word(sipq_pkg::FUNC_INSERT, fill_prio[k], 8'(k * 17)), 0);
        send_word(make_word(sipq_pkg::FUNC_INSERT, 16'h0000, 8'hA5), 0);
    endtask

    // Removing from the front, then inserting ties behind equal entries and removing the head again.
    task automatic test_ties_after_wrap();
        repeat (3)
            send_word(make_word(sipq_pkg::FUNC_REMOVE, 16'h0000, 8'h00), 0);
        send_word(make_word(sipq_pkg::FUNC_INSERT, 16'h0005, 8'h5A), 0);
        send_word(make_word(sipq_pkg::FUNC_INSERT, 16'hFFFF, 8'hC3), 0);
        send_word(make_word(sipq_pkg::FUNC_REMOVE, 16'h1234, 8'h56), 0);
    endtask

    // Words come in runs that favour filling, draining or a balance, so that the
    // queue keeps reaching both full and empty, with priorities drawn in several ways.
    task automatic test_random_words(input int n_words, input int idle_pct);
        int          insert_pct;
        t_prio_mode  mode;
        logic [15:0] prio;
        logic        func;
        insert_pct = 50;
        mode = PRIO_FULL;
        for (int k = 0; k < n_words; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0: mode = PRIO_TIES;
                    1: mode = PRIO_EDGES;
                    default: mode = PRIO_FULL;
                endcase
            end
            case (mode)
                PRIO_TIES: prio = 16'($urandom_range(0, 3));
                PRIO_EDGES: begin
                    case ($urandom_range(0, 5))
                        0: prio = 16'h0000;
                        1: prio = 16'h0001;
                        2: prio = 16'h7FFF;
                        3: prio = 16'h8000;
                        4: prio = 16'hFFFE;
                        default: prio = 16'hFFFF;
                    endcase
                end
                default: prio = 16'($urandom());
            endcase
            func = ($urandom_range(0, 99) < insert_pct) ? sipq_pkg::FUNC_INSERT
                                                        : sipq_pkg::FUNC_REMOVE;
            send_word(make_word(func, prio, 8'($urandom())), idle_pct);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_remove_from_empty();
        test_fill_and_overflow();
        test_ties_after_wrap();
        test_random_words(300, 0);
        test_random_words(300, 78);
        test_random_words(300, 26);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("covered %0d inserts, %0d removes, %0d refused as full, %0d refused as empty",
                 inserts_done, removes_done, refused_full, refused_empty);
        $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
